FILE: design/spi_mrb_pkg.sv
`timescale 1ns / 1ps

package spi_mrb_pkg;

    localparam int DEF_FIFO_DEPTH   = 8;
    localparam int DEF_SELECT_LINES = 4;

    localparam logic       KIND_READ  = 1'b0;
    localparam logic       KIND_WRITE = 1'b1;

    localparam logic [2:0] REG_CR1    = 3'd0;
    localparam logic [2:0] REG_CR2    = 3'd1;
    localparam logic [2:0] REG_SR     = 3'd2;
    localparam logic [2:0] REG_DR     = 3'd3;
    localparam logic [2:0] REG_CSCTRL = 3'd4;

    localparam logic [7:0] SR_RXNE     = 8'h01;
    localparam logic [7:0] SR_TXE      = 8'h02;
    localparam logic [7:0] SR_UNDERRUN = 8'h04;
    localparam logic [7:0] SR_OVERRUN  = 8'h08;

    localparam logic [7:0] CR2_TXEIE    = 8'h80;
    localparam logic [7:0] CR2_RXNEIE   = 8'h40;
    localparam logic [7:0] CR2_ERRIE    = 8'h20;
    localparam logic [7:0] CR2_WRITABLE = 8'hF0;

    localparam int SEL_PORT_BITS   = 4;
    localparam int CS_ACTIVE_SHIFT = 4;

    typedef logic [7:0] byte_t;

endpackage

FILE: design/spi_mrb_ram.sv
`timescale 1ns / 1ps

module spi_mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/spi_master_register_block_top.sv
// SPI master register block: one bus access (read or write of CR1, CR2, SR, DR or CSCTRL) is
// taken per clock and its result word appears in the next cycle in an output register, so the
// block sustains one access per cycle while m_ready stays high; a stalled result holds and
// input is taken again as soon as it moves on. A DR write reports the sent byte and pushes the
// slave reply into the receive FIFO (a RAM with a registered read port), or sets overrun if
// it is full; a DR read pops it through that port, or sets underrun if it is empty. FIFO_DEPTH
// sets the RAM depth, SELECT_LINES the number of live active-low chip selects (unused lines
// read 1). Receive entries start undefined after reset; only written entries are ever returned.
`timescale 1ns / 1ps

module spi_master_register_block_top #(
    parameter int FIFO_DEPTH   = spi_mrb_pkg::DEF_FIFO_DEPTH,
    parameter int SELECT_LINES = spi_mrb_pkg::DEF_SELECT_LINES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [2:0] s_reg_index,
    input  logic [7:0] s_write_data,
    input  logic [7:0] s_slave_reply,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_irq_level,
    output logic [3:0] m_chip_selects,
    output logic       m_byte_sent,
    output logic [7:0] m_sent_byte,
    output logic       m_bad_access
);

    import spi_mrb_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = CW + 1;

    byte_t          ctrl1_reg, ctrl1_next;
    byte_t          ctrl2_reg, ctrl2_next;
    byte_t          csctrl_reg, csctrl_next;
    logic           ovr_reg, ovr_next;
    logic           und_reg, und_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  head_reg, head_next;

    logic           out_valid_reg;
    byte_t          rdata_reg, rdata_next;
    logic           pop_reg, pop_next;
    logic           irq_reg, irq_next;
    logic [3:0]     cs_reg, cs_next;
    logic           sent_reg, sent_next;
    byte_t          sbyte_reg, sbyte_next;
    logic           bad_reg, bad_next;

    logic           push;
    logic           accept;
    logic [SW-1:0]  tail_sum;
    logic [AW-1:0]  tail;
    byte_t          ram_rdata;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // tail wraps without a divider since head plus count stays below twice the depth
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    always_comb begin
        if (tail_sum >= SW'(FIFO_DEPTH)) begin
            tail = AW'(tail_sum - SW'(FIFO_DEPTH));
        end else begin
            tail = AW'(tail_sum);
        end
    end

    always_comb begin
        ctrl1_next  = ctrl1_reg;
        ctrl2_next  = ctrl2_reg;
        csctrl_next = csctrl_reg;
        ovr_next    = ovr_reg;
        und_next    = und_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        rdata_next  = '0;
        pop_next    = 1'b0;
        sent_next   = 1'b0;
        sbyte_next  = '0;
        bad_next    = 1'b0;
        push        = 1'b0;
        case (s_reg_index)
            REG_CR1: begin
                if (s_kind == KIND_WRITE) begin
                    ctrl1_next = s_write_data;
                end else begin
                    rdata_next = ctrl1_reg;
                end
            end
            REG_CR2: begin
                if (s_kind == KIND_WRITE) begin
                    ctrl2_next = s_write_data & CR2_WRITABLE;
                end else begin
                    rdata_next = ctrl2_reg;
                end
            end
            REG_SR: begin
                if (s_kind == KIND_WRITE) begin
                    if ((s_write_data & SR_UNDERRUN) != '0) begin
                        und_next = 1'b0;
                    end
                    if ((s_write_data & SR_OVERRUN) != '0) begin
                        ovr_next = 1'b0;
                    end
                end else begin
                    rdata_next = SR_TXE;
                    if (count_reg != '0) begin
                        rdata_next = rdata_next | SR_RXNE;
                    end
                    if (und_reg) begin
                        rdata_next = rdata_next | SR_UNDERRUN;
                    end
                    if (ovr_reg) begin
                        rdata_next = rdata_next | SR_OVERRUN;
                    end
                end
            end
            REG_DR: begin
                if (s_kind == KIND_WRITE) begin
                    sent_next  = 1'b1;
                    sbyte_next = s_write_data;
                    if (count_reg < CW'(FIFO_DEPTH)) begin
                        push       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovr_next = 1'b1;
                    end
                end else begin
                    if (count_reg == '0) begin
                        und_next = 1'b1;
                    end else begin
                        pop_next   = 1'b1;
                        count_next = count_reg - CW'(1);
                        if (head_reg == AW'(FIFO_DEPTH - 1)) begin
                            head_next = '0;
                        end else begin
                            head_next = head_reg + AW'(1);
                        end
                    end
                end
            end
            REG_CSCTRL: begin
                if (s_kind == KIND_WRITE) begin
                    csctrl_next = s_write_data;
                end else begin
                    rdata_next = csctrl_reg;
                end
            end
            default: begin
                bad_next = 1'b1;
            end
        endcase
    end

    always_comb begin
        irq_next = 1'b0;
        if ((ctrl2_next & CR2_TXEIE) != '0) begin
            irq_next = 1'b1;
        end
        if (((ctrl2_next & CR2_RXNEIE) != '0) && (count_next != '0)) begin
            irq_next = 1'b1;
        end
        if (((ctrl2_next & CR2_ERRIE) != '0) && (ovr_next || und_next)) begin
            irq_next = 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < SEL_PORT_BITS; i++) begin
            cs_next[i] = !((i < SELECT_LINES) && csctrl_next[i]
                           && csctrl_next[i + CS_ACTIVE_SHIFT]);
        end
    end

    spi_mrb_ram #(
        .WIDTH(8),
        .DEPTH(FIFO_DEPTH)
    ) u_rx_ram (
        .aclk (aclk),
        .we   (accept && push),
        .waddr(tail),
        .wdata(s_slave_reply),
        .re   (accept && pop_next),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg     <= '0;
            ctrl2_reg     <= '0;
            csctrl_reg    <= '0;
            ovr_reg       <= 1'b0;
            und_reg       <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                ctrl1_reg  <= ctrl1_next;
                ctrl2_reg  <= ctrl2_next;
                csctrl_reg <= csctrl_next;
                ovr_reg    <= ovr_next;
                und_reg    <= und_next;
                count_reg  <= count_next;
                head_reg   <= head_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg <= rdata_next;
            pop_reg   <= pop_next;
            irq_reg   <= irq_next;
            cs_reg    <= cs_next;
            sent_reg  <= sent_next;
            sbyte_reg <= sbyte_next;
            bad_reg   <= bad_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = pop_reg ? ram_rdata : rdata_reg;
    assign m_irq_level    = irq_reg;
    assign m_chip_selects = cs_reg;
    assign m_byte_sent    = sent_reg;
    assign m_sent_byte    = sbyte_reg;
    assign m_bad_access   = bad_reg;

endmodule

FILE: design/spi_mrb_checker.sv
`timescale 1ns / 1ps

module spi_mrb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_byte_sent,
    input logic [7:0] m_sent_byte,
    input logic       m_bad_access
);

    // no result word right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("stalled result word changed");

    a_bad_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_access |-> m_read_data == 8'h00 && !m_byte_sent)
        else $error("bad access produced data or a send");

    a_sent_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_sent |-> m_sent_byte == 8'h00)
        else $error("sent byte nonzero without a send");

endmodule

bind spi_master_register_block_top spi_mrb_checker u_spi_mrb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_byte_sent (m_byte_sent),
    .m_sent_byte (m_sent_byte),
    .m_bad_access(m_bad_access)
);
